[design/i24alu_pkg.sv]
// Package for the checked 24-bit signed ALU: data width, operation codes and
// status codes. No dependencies; every other file imports it.
`timescale 1ns / 1ps

package i24alu_pkg;

  // Operand and result width
  localparam int unsigned DATA_WIDTH = 24;
  localparam int unsigned EXP_WIDTH  = 32;
  localparam int unsigned MODE_WIDTH = 3;
  localparam int unsigned STAT_WIDTH = 2;

  // Operation codes
  localparam logic [MODE_WIDTH-1:0] MODE_ADD = 3'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_SUB = 3'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_MUL = 3'd2;
  localparam logic [MODE_WIDTH-1:0] MODE_DIV = 3'd3;
  localparam logic [MODE_WIDTH-1:0] MODE_POW = 3'd4;
  localparam logic [MODE_WIDTH-1:0] MODE_CMP = 3'd5;

  // Status codes
  localparam logic [STAT_WIDTH-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_WIDTH-1:0] ST_OVF  = 2'd1;
  localparam logic [STAT_WIDTH-1:0] ST_DIV0 = 2'd2;

endpackage

[design/i24alu_if.sv]
// Handshake channels of the checked ALU: request (operation and operands) and
// response (result, status, equality flag). Depends on i24alu_pkg.
`timescale 1ns / 1ps

interface i24alu_req_if import i24alu_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic        [MODE_WIDTH-1:0]  mode;
  logic signed [DATA_WIDTH-1:0]  operand_a;
  logic signed [DATA_WIDTH-1:0]  operand_b;
  logic        [EXP_WIDTH-1:0]   exponent;

  modport source (output valid, mode, operand_a, operand_b, exponent, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, exponent, output ready);
endinterface

interface i24alu_rsp_if import i24alu_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [DATA_WIDTH-1:0]  result;
  logic        [STAT_WIDTH-1:0]  status;
  logic                          equal;

  modport source (output valid, result, status, equal, input ready);
  modport sink   (input valid, result, status, equal, output ready);
endinterface

[design/int24_checked_alu_core.sv]
// Checked signed 24-bit ALU top level: sequencer around one shared multiplier
// and one shared adder. Depends on i24alu_pkg and the channels in i24alu_if.sv.
//
//  channel | dir | payload                                  | transfer
//  req_i   | in  | mode, operand_a, operand_b, exponent     | valid & ready
//  rsp_o   | out | result, status, equal                    | valid & ready
//
// Add, subtract, multiply, compare: worked out in the run state, then written to the output register.
// Divide: the 24 restoring steps on the shared adder, then the sign step; a zero
// divisor answers straight from the run state, with no steps.
// Power: one round of the shared multiplier per exponent step.
// Reset clears the sequencer and the response valid; no clearing pass.
// A request is taken only while the sequencer is idle; a stalled response is
// held in the output register and the next request may already be taken.
`timescale 1ns / 1ps

module int24_checked_alu_core import i24alu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  i24alu_req_if.sink       req_i,
  i24alu_rsp_if.source     rsp_o
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned CW = $clog2(DW + 1);

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DFIN  = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [MODE_WIDTH-1:0]   mode_q;
  logic signed [DW-1:0]    a_q, b_q;
  logic [EXP_WIDTH-1:0]    exp_q;
  logic signed [DW-1:0]    acc_q, acc_d;
  logic [DW-1:0]           quo_q, quo_d;
  logic [DW-1:0]           rem_q, rem_d;
  logic [DW-1:0]           dmag_q;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic signed [DW-1:0]    res_q, res_d;
  logic [STAT_WIDTH-1:0]   st_q, st_d;
  logic                    eq_q, eq_d;

  logic                    out_valid_q;
  logic signed [DW-1:0]    out_res_q;
  logic [STAT_WIDTH-1:0]   out_st_q;
  logic                    out_eq_q;

  logic                    req_xfer;
  logic                    out_load;

  // Shared multiplier
  logic signed [DW-1:0]    mul_x;
  logic signed [2*DW-1:0]  prod;
  logic                    prod_fits;

  // Shared adder, two guard bits
  logic [DW+1:0]           add_x, add_y, add_sum;
  logic                    add_sub;
  logic                    sum_fits;

  // Divide step and finish
  logic [DW-1:0]           cand;
  logic [DW-1:0]           quo_neg;
  logic                    div_neg;

  // Power handling
  logic                    pow_trivial;
  logic [EXP_WIDTH-1:0]    round_next;

  assign req_xfer    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign out_load    = (state_q == S_WRITE) && (!out_valid_q || rsp_o.ready);

  // Multiplier: acc * a in power mode, b * a in multiply mode
  assign mul_x     = (mode_q == MODE_POW) ? acc_q : b_q;
  assign prod      = mul_x * a_q;
  assign prod_fits = (&prod[2*DW-1:DW-1]) || !(|prod[2*DW-1:DW-1]);

  // Adder operand selection: divide step or add / subtract
  assign cand = {rem_q[DW-2:0], quo_q[DW-1]};
  always_comb begin
    if (mode_q == MODE_DIV) begin
      add_x   = {2'b00, cand};
      add_y   = {2'b00, dmag_q};
      add_sub = 1'b1;
    end else begin
      add_x   = {{2{a_q[DW-1]}}, a_q};
      add_y   = {{2{b_q[DW-1]}}, b_q};
      add_sub = (mode_q == MODE_SUB);
    end
  end
  assign add_sum  = add_x + (add_sub ? ~add_y : add_y) + {{(DW+1){1'b0}}, add_sub};
  assign sum_fits = (&add_sum[DW+1:DW-1]) || !(|add_sum[DW+1:DW-1]);

  assign div_neg = a_q[DW-1] ^ b_q[DW-1];
  assign quo_neg = ~quo_q + {{(DW-1){1'b0}}, 1'b1};

  assign pow_trivial = (exp_q == '0) || (a_q == '0) || (a_q == {{(DW-1){1'b0}}, 1'b1})
                       || (a_q == {DW{1'b1}});
  assign round_next  = {{(EXP_WIDTH-CW){1'b0}}, cnt_q} + {{(EXP_WIDTH-1){1'b0}}, 1'b1};

  // Sequencer and per-mode work
  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    st_d    = st_q;
    eq_d    = eq_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_xfer) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        state_d = S_WRITE;
        res_d   = '0;
        st_d    = ST_OK;
        eq_d    = 1'b0;
        case (mode_q)
          MODE_ADD, MODE_SUB: begin
            if (sum_fits) res_d = add_sum[DW-1:0];
            else          st_d  = ST_OVF;
          end
          MODE_MUL: begin
            if (prod_fits) res_d = prod[DW-1:0];
            else           st_d  = ST_OVF;
          end
          MODE_DIV: begin
            if (dmag_q == '0) begin
              st_d = ST_DIV0;
            end else begin
              // one restoring step
              state_d = S_RUN;
              if (add_sum[DW+1]) begin
                rem_d = cand;
                quo_d = {quo_q[DW-2:0], 1'b0};
              end else begin
                rem_d = add_sum[DW-1:0];
                quo_d = {quo_q[DW-2:0], 1'b1};
              end
              cnt_d = cnt_q + 1'b1;
              if (cnt_q == CW'(DW - 1)) state_d = S_DFIN;
            end
          end
          MODE_POW: begin
            if (exp_q == '0) begin
              res_d = DW'(1);
            end else if (pow_trivial) begin
              // base of zero, one or minus one
              if (a_q == {DW{1'b1}} && !exp_q[0]) res_d = DW'(1);
              else                                res_d = a_q;
            end else if (!prod_fits) begin
              st_d = ST_OVF;
            end else if (round_next == exp_q) begin
              res_d = prod[DW-1:0];
            end else begin
              // one more round
              state_d = S_RUN;
              acc_d   = prod[DW-1:0];
              cnt_d   = cnt_q + 1'b1;
            end
          end
          MODE_CMP: begin
            eq_d = (a_q == b_q);
          end
          default: begin
          end
        endcase
      end
      S_DFIN: begin
        // apply sign, catch the one quotient that does not fit
        state_d = S_WRITE;
        eq_d    = 1'b0;
        if (!div_neg && quo_q[DW-1]) begin
          res_d = '0;
          st_d  = ST_OVF;
        end else begin
          res_d = div_neg ? quo_neg : quo_q;
          st_d  = ST_OK;
        end
      end
      S_WRITE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Operand capture and working registers
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      mode_q <= req_i.mode;
      a_q    <= req_i.operand_a;
      b_q    <= req_i.operand_b;
      exp_q  <= req_i.exponent;
      acc_q  <= DW'(1);
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= req_i.operand_a[DW-1] ? (~req_i.operand_a + DW'(1)) : req_i.operand_a;
      dmag_q <= req_i.operand_b[DW-1] ? (~req_i.operand_b + DW'(1)) : req_i.operand_b;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    res_q <= res_d;
    st_q  <= st_d;
    eq_q  <= eq_d;
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q <= res_q;
      out_st_q  <= st_q;
      out_eq_q  <= eq_q;
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.result = out_res_q;
  assign rsp_o.status = out_st_q;
  assign rsp_o.equal  = out_eq_q;

`ifndef SYNTHESIS
  // Any failing status comes with a zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != ST_OK) |-> rsp_o.result == '0)
    else $error("non-zero result with failing status");

  // Equality flag only ever set on a clean compare
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.equal |-> (rsp_o.status == ST_OK) && (rsp_o.result == '0))
    else $error("equal flag outside compare result");

  // Divide never runs past its last step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) && (mode_q == MODE_DIV) |-> cnt_q < CW'(DW))
    else $error("divide step count overrun");

  // A taken request starts work at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> state_q == S_RUN)
    else $error("request taken but sequencer did not start");

  // Power rounds stay within the width bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) && (mode_q == MODE_POW) |-> cnt_q <= CW'(DW))
    else $error("power round count overrun");
`endif

endmodule

[tb/sv/int24_checked_alu_core_tb.sv]
// Self-checking testbench for int24_checked_alu_core: directed corner cases, then
// random requests with random idling on both channels, scored against an exact predictor.
// Depends on i24alu_pkg, the channels in i24alu_if.sv and the core itself.
`timescale 1ns / 1ps

module int24_checked_alu_core_tb;
  import i24alu_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 5;
  localparam int RANDOM_ITEMS  = 930;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 600000;

  // Spare opcodes: the core must answer them with an all-zero response
  localparam logic [MODE_WIDTH-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_WIDTH-1:0] MODE_SPARE7 = 3'd7;

  localparam logic signed [DATA_WIDTH-1:0] OPND_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] OPND_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct {
    logic        [MODE_WIDTH-1:0] mode;
    logic signed [DATA_WIDTH-1:0] operand_a;
    logic signed [DATA_WIDTH-1:0] operand_b;
    logic        [EXP_WIDTH-1:0]  exponent;
    logic signed [DATA_WIDTH-1:0] result;
    logic        [STAT_WIDTH-1:0] status;
    logic                         equal;
  } alu_outcome_t;

  // Predicts each response from the request and matches responses in order
  class alu_outcome_board;
    localparam int MAX_REPORTS = 10;
    alu_outcome_t awaited_outcomes[$];
    int mismatches;
    int ok_count;
    int ovf_count;
    int div0_count;
    int equal_count;

    function new();
      mismatches  = 0;
      ok_count    = 0;
      ovf_count   = 0;
      div0_count  = 0;
      equal_count = 0;
    endfunction

    // Exact power; a magnitude of two or more overflows within DATA_WIDTH rounds
    function bit exact_power(input longint base, input logic [EXP_WIDTH-1:0] n,
                             output longint res);
      longint      acc;
      longint      hi;
      longint      lo;
      int unsigned i;
      hi = (longint'(1) << (DATA_WIDTH - 1)) - 1;
      lo = -hi - 1;
      res = 0;
      if (n == 0) begin
        res = 1;
        return 1'b1;
      end
      if (base == 0 || base == 1) begin
        res = base;
        return 1'b1;
      end
      if (base == -1) begin
        res = n[0] ? -1 : 1;
        return 1'b1;
      end
      acc = 1;
      for (i = 0; i < n && i <= DATA_WIDTH; i++) begin
        acc = acc * base;
        if (acc > hi || acc < lo) return 1'b0;
      end
      if (i < n) return 1'b0;
      res = acc;
      return 1'b1;
    endfunction

    function alu_outcome_t checked_alu_outcome(input logic [MODE_WIDTH-1:0] mode,
                                               input logic signed [DATA_WIDTH-1:0] a,
                                               input logic signed [DATA_WIDTH-1:0] b,
                                               input logic [EXP_WIDTH-1:0] e);
      alu_outcome_t o;
      longint       x;
      longint       y;
      longint       r;
      longint       hi;
      longint       lo;
      bit           range_check;
      hi = (longint'(1) << (DATA_WIDTH - 1)) - 1;
      lo = -hi - 1;
      x = longint'(a);
      y = longint'(b);
      r = 0;
      range_check = 1'b0;
      o.mode = mode;
      o.operand_a = a;
      o.operand_b = b;
      o.exponent = e;
      o.status = ST_OK;
      o.equal = 1'b0;
      case (mode)
        MODE_ADD: begin
          r = x + y;
          range_check = 1'b1;
        end
        MODE_SUB: begin
          r = x - y;
          range_check = 1'b1;
        end
        MODE_MUL: begin
          r = x * y;
          range_check = 1'b1;
        end
        MODE_DIV: begin
          if (y == 0) begin
            o.status = ST_DIV0;
          end else begin
            // longint division truncates toward zero
            r = x / y;
            range_check = 1'b1;
          end
        end
        MODE_POW: begin
          if (!exact_power(x, e, r)) o.status = ST_OVF;
        end
        MODE_CMP: o.equal = (x == y);
        default: ;
      endcase
      if (range_check && (r > hi || r < lo)) o.status = ST_OVF;
      if (o.status != ST_OK) r = 0;
      o.result = r[DATA_WIDTH-1:0];
      return o;
    endfunction

    function void note_request(input logic [MODE_WIDTH-1:0] mode,
                               input logic signed [DATA_WIDTH-1:0] a,
                               input logic signed [DATA_WIDTH-1:0] b,
                               input logic [EXP_WIDTH-1:0] e);
      awaited_outcomes.push_back(checked_alu_outcome(mode, a, b, e));
    endfunction

    function void check_response(input logic signed [DATA_WIDTH-1:0] got_result,
                                 input logic [STAT_WIDTH-1:0] got_status,
                                 input logic got_equal);
      alu_outcome_t want;
      if (awaited_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] response with no request outstanding: result %0d status %0d equal %0b",
                   $realtime, got_result, got_status, got_equal);
        return;
      end
      want = awaited_outcomes.pop_front();
      if (got_result !== want.result || got_status !== want.status ||
          got_equal !== want.equal) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] mismatch: mode %0d a %0d b %0d exp %0d: want %0d/%0d/%0b got %0d/%0d/%0b",
                   $realtime, want.mode, want.operand_a, want.operand_b, want.exponent,
                   want.result, want.status, want.equal, got_result, got_status, got_equal);
      end
      case (want.status)
        ST_OK:   ok_count++;
        ST_OVF:  ovf_count++;
        ST_DIV0: div0_count++;
        default: ;
      endcase
      if (want.equal) equal_count++;
    endfunction

    function int outstanding();
      return awaited_outcomes.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  i24alu_req_if req_ch ();
  i24alu_rsp_if rsp_ch ();

  int24_checked_alu_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  alu_outcome_board board;
  int               mode_count [8];
  int               cycle_count;
  bit               steady_flow;
  bit               hold_request;

  // Clock and cycle watchdog
  initial clk_i = 1'b0;
  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, board.outstanding());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Score every response transfer
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready)
      board.check_response(rsp_ch.result, rsp_ch.status, rsp_ch.equal);
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_cycles();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] pick_operand();
    logic signed [DATA_WIDTH-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = OPND_MAX;
          1:       v = OPND_MIN;
          2:       v = '0;
          3:       v = 1;
          default: v = -1;
        endcase
      end
      1, 2:    v = DATA_WIDTH'(int'($urandom_range(0, 600)) - 300);
      // around the square root of the range, where products start to overflow
      3, 4:    v = DATA_WIDTH'(int'($urandom_range(0, 8192)) - 4096);
      default: v = DATA_WIDTH'($urandom);
    endcase
    return v;
  endfunction

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        rsp_ch.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready = 1'b1;
        if (!steady_flow && $urandom_range(0, 99) < 25) stall_left = idle_cycles();
      end
    end
  end

  // Offer one request from a falling edge and hold it until the transfer
  task automatic send_request(input logic [MODE_WIDTH-1:0] m,
                              input logic signed [DATA_WIDTH-1:0] a,
                              input logic signed [DATA_WIDTH-1:0] b,
                              input logic [EXP_WIDTH-1:0] e);
    req_ch.valid     = 1'b1;
    req_ch.mode      = m;
    req_ch.operand_a = a;
    req_ch.operand_b = b;
    req_ch.exponent  = e;
    do @(posedge clk_i); while (!req_ch.ready);
    board.note_request(m, a, b, e);
    mode_count[m]++;
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      req_ch.valid = 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  task automatic wait_all_answered();
    req_ch.valid = 1'b0;
    while (board.outstanding() != 0) @(negedge clk_i);
  endtask

  task automatic send_random_request();
    int unsigned                  pick;
    logic        [MODE_WIDTH-1:0] m;
    logic signed [DATA_WIDTH-1:0] a;
    logic signed [DATA_WIDTH-1:0] b;
    logic        [EXP_WIDTH-1:0]  e;
    pick = $urandom_range(0, 99);
    if (pick < 16)      m = MODE_ADD;
    else if (pick < 32) m = MODE_SUB;
    else if (pick < 48) m = MODE_MUL;
    else if (pick < 66) m = MODE_DIV;
    else if (pick < 86) m = MODE_POW;
    else if (pick < 96) m = MODE_CMP;
    else if (pick < 98) m = MODE_SPARE6;
    else                m = MODE_SPARE7;
    a = pick_operand();
    b = pick_operand();
    e = $urandom;
    if (m == MODE_DIV && $urandom_range(0, 9) == 0) b = '0;
    if (m == MODE_CMP && $urandom_range(0, 1) == 1) b = a;
    if (m == MODE_POW) begin
      // keep most bases and exponents small so many powers stay in range
      case ($urandom_range(0, 9))
        0:                a = DATA_WIDTH'(int'($urandom_range(0, 2)) - 1);
        1, 2, 3, 4, 5, 6: a = DATA_WIDTH'(int'($urandom_range(0, 40)) - 20);
        default: ;
      endcase
      if ($urandom_range(0, 9) < 8) e = $urandom_range(0, 30);
    end
    send_request(m, a, b, e);
  endtask

  // Stimulus and end of run
  initial begin
    board = new();
    cycle_count = 0;
    steady_flow = 1'b0;
    hold_request = 1'b0;
    foreach (mode_count[i]) mode_count[i] = 0;
    req_ch.valid     = 1'b0;
    req_ch.mode      = MODE_ADD;
    req_ch.operand_a = '0;
    req_ch.operand_b = '0;
    req_ch.exponent  = '0;
    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed corners: range edges, every opcode and the special cases
    send_request(MODE_ADD, OPND_MAX, OPND_MAX, 32'd0);
    send_request(MODE_ADD, OPND_MIN, OPND_MIN, 32'hFFFF_FFFF);
    send_request(MODE_ADD, OPND_MAX, -1, 32'd0);
    send_request(MODE_SUB, OPND_MIN, 1, 32'd0);
    send_request(MODE_SUB, '0, OPND_MIN, 32'd0);
    send_request(MODE_SUB, -1, OPND_MIN, 32'd0);
    send_request(MODE_MUL, OPND_MAX, OPND_MAX, 32'd0);
    send_request(MODE_MUL, -1, OPND_MIN, 32'd0);
    send_request(MODE_MUL, OPND_MIN, 1, 32'd0);
    send_request(MODE_MUL, 4096, -2048, 32'd0);
    send_request(MODE_DIV, 12345, '0, 32'd0);
    send_request(MODE_DIV, OPND_MIN, -1, 32'd0);
    send_request(MODE_DIV, -7, 2, 32'd0);
    send_request(MODE_DIV, 7, -2, 32'd0);
    send_request(MODE_POW, '0, '0, 32'd0);
    send_request(MODE_POW, 2, '0, 32'd22);
    send_request(MODE_POW, 2, '0, 32'd23);
    send_request(MODE_POW, -2, '0, 32'd23);
    send_request(MODE_POW, -1, '0, 32'hFFFF_FFFF);
    send_request(MODE_POW, 5, '0, 32'hFFFF_FFFF);
    send_request(MODE_POW, '0, '0, 32'h8000_0000);
    send_request(MODE_CMP, OPND_MIN, OPND_MIN, 32'd0);
    send_request(MODE_CMP, OPND_MAX, OPND_MIN, 32'd0);
    send_request(MODE_SPARE6, OPND_MAX, OPND_MAX, 32'hFFFF_FFFF);
    send_request(MODE_SPARE7, OPND_MIN, -1, 32'hFFFF_FFFF);
    wait_all_answered();

    // Random requests with phases of steady flow, a drain and a long output stall
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_flow = (n >= 200 && n < 300);
      if (n == 450) wait_all_answered();
      if (n == 600) hold_request = 1'b1;
      if (!steady_flow && !(n >= 600 && n < 640)) pause_sender(idle_cycles());
      send_random_request();
    end
    req_ch.valid = 1'b0;

    wait_all_answered();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Requests: add %0d sub %0d mul %0d div %0d pow %0d cmp %0d spare %0d",
             mode_count[MODE_ADD], mode_count[MODE_SUB], mode_count[MODE_MUL],
             mode_count[MODE_DIV], mode_count[MODE_POW], mode_count[MODE_CMP],
             mode_count[MODE_SPARE6] + mode_count[MODE_SPARE7]);
    $display("Responses: %0d ok, %0d overflow, %0d divide by zero, %0d equal; %0d mismatches",
             board.ok_count, board.ovf_count, board.div0_count, board.equal_count,
             board.mismatches);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
